// File: hdl/trq_pkg.sv
package trq_pkg;

    localparam int TID_W   = 5;
    localparam int CODE_W  = 3;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_YIELD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [CODE_W-1:0] CODE_READY = 3'd0;
    localparam logic [CODE_W-1:0] CODE_RESET = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TID_W-1:0]  thread_id;
        logic [CODE_W-1:0] new_state;
    } op_t;

    typedef struct packed {
        logic [CODE_W-1:0] old_state;
        logic              op_error;
        logic              queue_empty;
        logic [TID_W-1:0]  head_thread;
    } res_t;

endpackage

// File: hdl/trq_ring.sv
module trq_ring
    import trq_pkg::*;
#(
    parameter int MAX_THREADS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic exec,
    input  op_t  op,
    output res_t result
);

    localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

    logic [IDX_W-1:0]  head_reg;
    logic              valid_reg;
    logic [IDX_W-1:0]  next_link_reg [MAX_THREADS];
    logic [IDX_W-1:0]  prev_link_reg [MAX_THREADS];
    logic [CODE_W-1:0] code_reg      [MAX_THREADS];

    logic [IDX_W-1:0]  head_next;
    logic              valid_next;

    logic              in_range;
    logic [IDX_W-1:0]  t_idx;
    logic [IDX_W-1:0]  t_next;
    logic [IDX_W-1:0]  t_prev;
    logic [IDX_W-1:0]  tail_idx;
    logic [CODE_W-1:0] old_code;
    logic              err;
    logic              code_we;

    // three write ports per link table; addresses never collide within one op
    logic [2:0]            nx_we;
    logic [2:0][IDX_W-1:0] nx_wa;
    logic [2:0][IDX_W-1:0] nx_wd;
    logic [2:0]            pv_we;
    logic [2:0][IDX_W-1:0] pv_wa;
    logic [2:0][IDX_W-1:0] pv_wd;

    assign in_range = (int'(op.thread_id) < MAX_THREADS);
    assign t_idx    = IDX_W'(op.thread_id);
    assign t_next   = next_link_reg[t_idx];
    assign t_prev   = prev_link_reg[t_idx];
    assign tail_idx = prev_link_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        valid_next = valid_reg;
        old_code   = CODE_RESET;
        err        = 1'b0;
        code_we    = 1'b0;
        nx_we      = '0;
        nx_wa      = '0;
        nx_wd      = '0;
        pv_we      = '0;
        pv_wa      = '0;
        pv_wd      = '0;
        if (!in_range)
        begin
            err = 1'b1;
        end
        else
        begin
            old_code = code_reg[t_idx];
            case (op.func)
                FUNC_SET:
                begin
                    if (op.new_state == CODE_READY)
                    begin
                        if (old_code == CODE_READY)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            code_we = 1'b1;
                            if (!valid_reg)
                            begin
                                nx_we[0] = 1'b1; nx_wa[0] = t_idx; nx_wd[0] = t_idx;
                                pv_we[0] = 1'b1; pv_wa[0] = t_idx; pv_wd[0] = t_idx;
                            end
                            else
                            begin
                                // splice in between tail and head, then take the head
                                nx_we[0] = 1'b1; nx_wa[0] = t_idx;    nx_wd[0] = head_reg;
                                pv_we[0] = 1'b1; pv_wa[0] = t_idx;    pv_wd[0] = tail_idx;
                                nx_we[1] = 1'b1; nx_wa[1] = tail_idx; nx_wd[1] = t_idx;
                                pv_we[1] = 1'b1; pv_wa[1] = head_reg; pv_wd[1] = t_idx;
                            end
                            head_next  = t_idx;
                            valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        code_we = 1'b1;
                        if (old_code == CODE_READY)
                        begin
                            nx_we[0] = 1'b1; nx_wa[0] = t_prev; nx_wd[0] = t_next;
                            pv_we[0] = 1'b1; pv_wa[0] = t_next; pv_wd[0] = t_prev;
                            if (head_reg == t_idx)
                            begin
                                if (t_next == t_idx)
                                begin
                                    valid_next = 1'b0;
                                    head_next  = '0;
                                end
                                else
                                begin
                                    head_next = t_next;
                                end
                            end
                        end
                    end
                end
                FUNC_YIELD:
                begin
                    if (old_code != CODE_READY)
                    begin
                        err = 1'b1;
                    end
                    else if (t_next != t_idx)
                    begin
                        if (head_reg == t_idx)
                        begin
                            // the head moving to the tail just advances the head
                            head_next = t_next;
                        end
                        else if (t_next != head_reg)
                        begin
                            // unlink, then splice in between tail and head
                            nx_we[0] = 1'b1; nx_wa[0] = t_prev;   nx_wd[0] = t_next;
                            pv_we[0] = 1'b1; pv_wa[0] = t_next;   pv_wd[0] = t_prev;
                            nx_we[1] = 1'b1; nx_wa[1] = t_idx;    nx_wd[1] = head_reg;
                            pv_we[1] = 1'b1; pv_wa[1] = t_idx;    pv_wd[1] = tail_idx;
                            nx_we[2] = 1'b1; nx_wa[2] = tail_idx; nx_wd[2] = t_idx;
                            pv_we[2] = 1'b1; pv_wa[2] = head_reg; pv_wd[2] = t_idx;
                        end
                    end
                end
                FUNC_QUERY:
                begin
                    err = 1'b0;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            valid_reg <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                code_reg[i] <= CODE_RESET;
            end
        end
        else if (exec)
        begin
            head_reg  <= head_next;
            valid_reg <= valid_next;
            if (code_we)
            begin
                code_reg[t_idx] <= op.new_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (nx_we[k] && nx_wa[k] == IDX_W'(i))
                    begin
                        next_link_reg[i] <= nx_wd[k];
                    end
                    if (pv_we[k] && pv_wa[k] == IDX_W'(i))
                    begin
                        prev_link_reg[i] <= pv_wd[k];
                    end
                end
            end
        end
    end

    assign result.head_thread = valid_next ? TID_W'(head_next) : '0;
    assign result.queue_empty = !valid_next;
    assign result.op_error    = err;
    assign result.old_state   = old_code;

    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> head_reg == '0)
        else $error("empty queue with nonzero head");

    a_head_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> code_reg[head_reg] == CODE_READY)
        else $error("head thread not in ready state");

    a_error_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        exec && err |=> $stable(head_reg) && $stable(valid_reg))
        else $error("rejected operation changed the queue head");

    a_ready_takes_head: assert property (@(posedge clk) disable iff (!rst_n)
        exec && code_we && op.new_state == CODE_READY
        |=> valid_reg && head_reg == $past(t_idx))
        else $error("thread made ready did not become head");

endmodule

// File: hdl/thread_ready_queue_core.sv
// Channel   Dir  Bits  Contents
// s_tdata   in   8     thread_id[4:0], new_state[7:5]
// s_tuser   in   2     func
// m_tdata   out  16    head_thread[4:0], queue_empty[5], op_error[6], old_state[9:7]
//
// One beat in, one beat out; sustained rate one beat per cycle while the output is not stalled.
// Each beat passes through the input register, then the ring update and result register.
// The ring update is a single pass over register-file link tables (no memory ports).
// Reset clears the head, marks every thread not ready; link tables need no clearing.
// A stalled output holds its result; the input side keeps flowing as long as the
// result register is empty or being drained in the same cycle.
module thread_ready_queue_core
    import trq_pkg::*;
#(
    parameter int MAX_THREADS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // thread_id[4:0], new_state[7:5]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // head_thread[4:0], queue_empty, op_error, old_state
);

    logic in_valid_reg;
    op_t  in_op_reg;
    logic out_valid_reg;
    res_t out_res_reg;

    logic advance;
    res_t ring_res;

    // advance when the result register is free or drains this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: capture the beat, hold the result
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg.func      <= s_tuser;
            in_op_reg.thread_id <= s_tdata[4:0];
            in_op_reg.new_state <= s_tdata[7:5];
        end
        if (advance)
        begin
            out_res_reg <= ring_res;
        end
    end

    trq_ring #(
        .MAX_THREADS(MAX_THREADS)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (advance),
        .op    (in_op_reg),
        .result(ring_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.old_state, out_res_reg.op_error,
                       out_res_reg.queue_empty, out_res_reg.head_thread};

endmodule

// File: test/trq_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels, tracks the ready ring in its own tables
// and compares each output beat with the oldest prediction.
module trq_checker
    import trq_pkg::*;
#(
    parameter int MAX_THREADS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // thread_id[4:0], new_state[7:5]
    input  logic [1:0]  s_tuser,   // func[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // head_thread[4:0], queue_empty, op_error, old_state
    output int          mismatches,
    output int          pending,
    output int          results_seen,
    output int          invalid_ops,
    output int          max_ready
);

    logic [TID_W-1:0]  ring_next [MAX_THREADS];
    logic [TID_W-1:0]  ring_prev [MAX_THREADS];
    logic [CODE_W-1:0] slot_code [MAX_THREADS];
    logic [TID_W-1:0]  head;
    logic              head_live;
    int                ready_count;
    res_t              expected_q [$];

    function automatic void ring_remove(logic [TID_W-1:0] t);
        logic [TID_W-1:0] n;
        logic [TID_W-1:0] p;
        n = ring_next[t];
        p = ring_prev[t];
        ring_next[p] = n;
        ring_prev[n] = p;
        if (head == t)
        begin
            if (n == t)
            begin
                head_live = 1'b0;
                head      = '0;
            end
            else
                head = n;
        end
    endfunction

    // link just before the head, i.e. at the tail of the run order
    function automatic void ring_append(logic [TID_W-1:0] t);
        logic [TID_W-1:0] p;
        if (!head_live)
        begin
            ring_next[t] = t;
            ring_prev[t] = t;
            head         = t;
            head_live    = 1'b1;
        end
        else
        begin
            p               = ring_prev[head];
            ring_next[t]    = head;
            ring_prev[t]    = p;
            ring_next[p]    = t;
            ring_prev[head] = t;
        end
    endfunction

    function automatic res_t run_op(op_t op);
        res_t              r;
        logic              err;
        logic [CODE_W-1:0] prior;
        logic [TID_W-1:0]  t;
        err   = 1'b0;
        prior = CODE_RESET;
        t     = op.thread_id;
        if (int'(t) >= MAX_THREADS)
            err = 1'b1;
        else
        begin
            prior = slot_code[t];
            case (op.func)
                FUNC_SET:
                    if (op.new_state == CODE_READY)
                    begin
                        if (prior == CODE_READY)
                            err = 1'b1;
                        else
                        begin
                            ring_append(t);
                            head         = t;
                            slot_code[t] = op.new_state;
                            ready_count++;
                        end
                    end
                    else
                    begin
                        if (prior == CODE_READY)
                        begin
                            ring_remove(t);
                            ready_count--;
                        end
                        slot_code[t] = op.new_state;
                    end
                FUNC_YIELD:
                    if (prior != CODE_READY)
                        err = 1'b1;
                    else
                    begin
                        ring_remove(t);
                        ring_append(t);
                    end
                FUNC_QUERY: ;
                default: err = 1'b1;
            endcase
        end
        r.head_thread = head_live ? head : '0;
        r.queue_empty = !head_live;
        r.op_error    = err;
        r.old_state   = prior;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
        if (mismatches < 10)
            $display("trq_checker: %s wrong at %0t: expected %0h, got %0h",
                     what, $realtime, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        op_t  op;
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
                slot_code[i] = CODE_RESET;
            head         = '0;
            head_live    = 1'b0;
            ready_count  = 0;
            max_ready    = 0;
            mismatches   = 0;
            results_seen = 0;
            invalid_ops  = 0;
            expected_q.delete();
            pending     <= 0;
        end
        else
        begin
            // predict first, so a beat accepted at this edge is queued in order
            if (s_tvalid && s_tready)
            begin
                op.func      = s_tuser;
                op.thread_id = s_tdata[4:0];
                op.new_state = s_tdata[7:5];
                want         = run_op(op);
                if (want.op_error)
                    invalid_ops++;
                if (ready_count > max_ready)
                    max_ready = ready_count;
                expected_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = m_tdata[9:0];
                if (expected_q.size() == 0)
                    note_mismatch("unexpected beat", '0, m_tdata);
                else
                begin
                    want = expected_q.pop_front();
                    // head is only meaningful while some thread is ready
                    if (!want.queue_empty && got.head_thread !== want.head_thread)
                        note_mismatch("head_thread", 16'(want.head_thread),
                                      16'(got.head_thread));
                    if (got.queue_empty !== want.queue_empty)
                        note_mismatch("queue_empty", 16'(want.queue_empty),
                                      16'(got.queue_empty));
                    if (got.op_error !== want.op_error)
                        note_mismatch("op_error", 16'(want.op_error), 16'(got.op_error));
                    if (got.old_state !== want.old_state)
                        note_mismatch("old_state", 16'(want.old_state), 16'(got.old_state));
                    if (m_tdata[15:10] !== '0)
                        note_mismatch("padding", '0, 16'(m_tdata[15:10]));
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: test/thread_ready_queue_core_tb.sv
`timescale 1ns / 1ps

module thread_ready_queue_core_tb;
    import trq_pkg::*;

    localparam int MAX_THREADS = 32;
    // func code with no meaning; the block must flag and ignore it
    localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;
    localparam int RANDOM_OPS  = 700;
    localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
    localparam int SINK_HOLD   = 200;   // long output hold to back up the input

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // 1: sender idles 7%, receiver 88%; 2: the reverse; 3: no idling
    int phase;
    int ops_sent;
    int stall_cycles;

    int mismatches;
    int pending;
    int results_seen;
    int invalid_ops;
    int max_ready;

    thread_ready_queue_core #(
        .MAX_THREADS(MAX_THREADS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    trq_checker #(
        .MAX_THREADS(MAX_THREADS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .invalid_ops  (invalid_ops),
        .max_ready    (max_ready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_op(logic [FUNC_W-1:0] func, logic [TID_W-1:0] tid,
                           logic [CODE_W-1:0] state);
        int idle_pct;
        idle_pct = (phase == 1) ? 7 : (phase == 2) ? 88 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {state, tid};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ops_sent++;
    endtask

    // Mostly sets and yields on a small pool of slots so the ring grows,
    // shrinks and reorders; the rest spread over all slots, plus queries
    // and the odd meaningless func code.
    task automatic send_random();
        logic [FUNC_W-1:0] func;
        logic [TID_W-1:0]  tid;
        logic [CODE_W-1:0] state;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 45)
            func = FUNC_SET;
        else if (pick < 75)
            func = FUNC_YIELD;
        else if (pick < 94)
            func = FUNC_QUERY;
        else
            func = FUNC_BAD;
        if ($urandom_range(99) < 60)
            tid = TID_W'($urandom_range(7));
        else
            tid = TID_W'($urandom_range(MAX_THREADS - 1));
        if ($urandom_range(1) == 0)
            state = CODE_READY;
        else
            state = CODE_W'($urandom_range(7));
        send_op(func, tid, state);
    endtask

    // Receiver: random tready per phase; on entering the no-idle phase,
    // hold off for a long stretch while the sender keeps pushing.
    initial
    begin : sink
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (phase == 3 && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (SINK_HOLD)
                    @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= ((phase == 1) ? 88 : (phase == 2) ? 7 : 0));
            @(posedge clk);
        end
    end

    // Watchdog: end the run if no beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        phase        = 1;
        ops_sent     = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: walk the ring through its corner cases.
        send_op(FUNC_QUERY, 5'd0,  CODE_READY);   // query on an empty queue
        send_op(FUNC_YIELD, 5'd3,  CODE_READY);   // yield a thread that is not ready
        send_op(FUNC_SET,   5'd4,  3'd5);         // non-ready code on non-ready thread
        send_op(FUNC_SET,   5'd0,  CODE_READY);   // first ready thread
        send_op(FUNC_SET,   5'd0,  CODE_READY);   // already ready
        send_op(FUNC_YIELD, 5'd0,  CODE_READY);   // yield the only ready thread
        send_op(FUNC_SET,   5'd31, CODE_READY);   // new ready goes to the head
        send_op(FUNC_SET,   5'd5,  CODE_READY);
        send_op(FUNC_YIELD, 5'd5,  CODE_READY);   // yield the head
        send_op(FUNC_YIELD, 5'd0,  CODE_READY);   // yield from the middle
        send_op(FUNC_BAD,   5'd17, 3'd2);
        send_op(FUNC_SET,   5'd31, CODE_RESET);   // drop the head
        send_op(FUNC_SET,   5'd0,  3'd1);
        send_op(FUNC_SET,   5'd5,  3'd2);         // last ready one leaves
        send_op(FUNC_SET,   5'd5,  3'd3);
        send_op(FUNC_SET,   5'd18, CODE_READY);
        send_op(FUNC_SET,   5'd10, CODE_READY);
        send_op(FUNC_SET,   5'd18, 3'd4);         // drop the tail
        send_op(FUNC_SET,   5'd10, 3'd6);
        send_op(FUNC_QUERY, 5'd31, CODE_RESET);
        send_op(FUNC_SET,   5'd31, CODE_READY);
        send_op(FUNC_YIELD, 5'd31, CODE_READY);
        send_op(FUNC_BAD,   5'd31, CODE_RESET);

        // Random: three idle mixes, the last one opening with the output hold.
        for (int p = 1; p <= 3; p++)
        begin
            phase <= p;
            repeat (RANDOM_OPS / 3)
                send_random();
        end
        s_tvalid <= 1'b0;

        // drain: wait for every predicted beat, then a few cycles of quiet
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8)
            @(posedge clk);

        $display("tb: %0d ops sent, %0d result beats checked, %0d rejected as invalid",
                 ops_sent, results_seen, invalid_ops);
        $display("tb: up to %0d threads ready at once; idle mixes 7/88, 88/7, none, %0d-cycle hold",
                 max_ready, SINK_HOLD);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
